FILE: rtl/pnl_pkg.sv
// Shared types, constants and helpers of the periodic neighbour list builder.
`default_nettype none
package pnl_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;
  localparam int COORD_W       = 24;
  localparam int BOX_W         = 23;
  localparam int CUT_W         = 48;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 48;
  localparam int NUM_IMAGES    = 27;
  localparam int IMG_W         = 5;
  localparam int NUM_AXES      = 3;

  localparam logic [IMG_W-1:0] IMG_NONE = 5'd31;
  localparam logic [IMG_W-1:0] IMG_LAST = 5'd26;

  localparam logic [1:0] SHIFT_NEG  = 2'd0;
  localparam logic [1:0] SHIFT_ZERO = 2'd1;
  localparam logic [1:0] SHIFT_POS  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X  = 3'd0,
    CFG_BOX_Y  = 3'd1,
    CFG_BOX_Z  = 3'd2,
    CFG_CUTOFF = 3'd3,
    CFG_COUNT  = 3'd4
  } pnl_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LAT_I,
    ST_SCAN1,
    ST_DRAIN1,
    ST_PREFIX,
    ST_SCAN2,
    ST_DRAIN2,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_NONE
  } pnl_state_t;

  typedef struct packed {
    logic load_wr;
    logic start;
    logic rd_i;
    logic cap_ri;
    logic p1_issue;
    logic p2_issue;
    logic prefix_step;
    logic emit_rd;
    logic out_hit;
    logic out_none;
    logic first;
    logic last;
  } pnl_cmd_t;

  typedef struct packed {
    logic             pipe_empty;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } pnl_stat_t;

  // Image code from per-axis shift codes (shift + 1): 9*cx + 3*cy + cz.
  function automatic logic [IMG_W-1:0] img_code(input logic [1:0] cx, input logic [1:0] cy,
                                                  input logic [1:0] cz);
    logic [IMG_W-1:0] r;
    r = IMG_W'(cx) * IMG_W'(9) + IMG_W'(cy) * IMG_W'(3) + IMG_W'(cz);
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/periodic_neighbor_list_builder.sv
// Top level of the periodic neighbour list builder.
// Usage: a beat on the input channel either loads one particle position
// (operation 0) or asks for the neighbours of one particle (operation 1).
// A load is written in the cycle it is accepted and gives no result beat.
// A query scans every partner j with i < j < particle_count through a
// five-stage pair pipeline, one pair per cycle, applying the minimum-image
// shift per axis and comparing the squared distance with cutoff_sq.
// Hits are then bucketed by image code with a 27-step prefix pass and a
// second scan over the same partners, so results leave sorted by image and
// then by partner index. The result beats follow the two scans and the
// prefix pass; each beat is read from the result buffer and then written to
// the output register before the next one is read. At most RESULT_CAP beats
// are reported; the last carries overflow when more hits were found. A query
// with no hit gives a single beat marked no_neighbors. The input is ready
// only between queries. A stalled receiver holds the result register and
// the block waits.
// Reset is synchronous: it restores the configuration registers to their
// defaults and returns the sequencer to idle; the stores are not cleared.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
`default_nettype none
module periodic_neighbor_list_builder import pnl_pkg::*; #(
  parameter int RESULT_CAP = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_operation,
  input  wire logic [IDX_W-1:0]      in_particle_index,
  input  wire logic [COORD_W-1:0]    in_pos_x,
  input  wire logic [COORD_W-1:0]    in_pos_y,
  input  wire logic [COORD_W-1:0]    in_pos_z,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [IDX_W-1:0]           out_query_index,
  output logic [IDX_W-1:0]           out_neighbor_index,
  output logic [IMG_W-1:0]           out_image_code,
  output logic                       out_group_start,
  output logic                       out_no_neighbors,
  output logic                       out_overflow,
  output logic                       out_last
);

  localparam int HB_AW = (RESULT_CAP > 1) ? $clog2(RESULT_CAP) : 1;
  localparam int HC_W  = $clog2(RESULT_CAP + 1);

  pnl_cmd_t         cmd;
  pnl_stat_t        stat;
  logic [IDX_W-1:0] addr;
  logic [IMG_W-1:0] kk;
  logic [HB_AW-1:0] emit_addr;
  logic [HC_W-1:0]  hit_count;

  // The sequencer owns the input handshake and issues one command per cycle.
  pnl_ctrl #(.RESULT_CAP(RESULT_CAP)) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_operation      (in_operation),
    .in_particle_index (in_particle_index),
    .in_ready          (in_ready),
    .stat              (stat),
    .hit_count         (hit_count),
    .cmd               (cmd),
    .addr              (addr),
    .kk                (kk),
    .emit_addr         (emit_addr)
  );

  // The datapath holds the stores, the pair pipeline and the result register.
  pnl_datapath #(.RESULT_CAP(RESULT_CAP)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_particle_index  (in_particle_index),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .cmd                (cmd),
    .addr               (addr),
    .kk                 (kk),
    .emit_addr          (emit_addr),
    .stat               (stat),
    .hit_count          (hit_count),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_query_index    (out_query_index),
    .out_neighbor_index (out_neighbor_index),
    .out_image_code     (out_image_code),
    .out_group_start    (out_group_start),
    .out_no_neighbors   (out_no_neighbors),
    .out_overflow       (out_overflow),
    .out_last           (out_last)
  );

`ifndef SYNTHESIS
  // An empty query reports a single closing beat with blank neighbour fields.
  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_neighbors |-> out_last && !out_overflow &&
      out_neighbor_index == '0 && out_image_code == '0)
    else $error("no_neighbors beat malformed");

  // Overflow is only flagged on the closing beat of a query.
  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_last)
    else $error("overflow away from last beat");

  // No new item is taken while a result beat still waits mid-query.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready during result stream");
`endif

endmodule
`default_nettype wire

FILE: rtl/pnl_ctrl.sv
// Query sequencer of the periodic neighbour list builder.
`default_nettype none
module pnl_ctrl import pnl_pkg::*; #(
  parameter int RESULT_CAP = 64,
  localparam int HB_AW = (RESULT_CAP > 1) ? $clog2(RESULT_CAP) : 1,
  localparam int HC_W  = $clog2(RESULT_CAP + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_operation,
  input  wire logic [IDX_W-1:0] in_particle_index,
  output logic                  in_ready,
  input  wire pnl_stat_t        stat,
  input  wire logic [HC_W-1:0]  hit_count,
  output pnl_cmd_t              cmd,
  output logic [IDX_W-1:0]      addr,
  output logic [IMG_W-1:0]      kk,
  output logic [HB_AW-1:0]      emit_addr
);

  pnl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IMG_W-1:0] kk_r, kk_nxt;
  logic [HC_W-1:0]  e_r, e_nxt;
  logic             any_r, any_nxt;
  logic [CNT_W-1:0] n_clamp;
  logic [CNT_W-1:0] i_plus;
  logic             accept;
  logic             is_last;

  assign n_clamp = (stat.count > CNT_W'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES) : stat.count;
  assign i_plus  = CNT_W'(in_particle_index) + CNT_W'(1);
  assign accept  = in_valid && (state_r == ST_IDLE);
  assign is_last = (HC_W'(e_r + HC_W'(1)) == hit_count);

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    kk_nxt    = kk_r;
    e_nxt     = e_r;
    any_nxt   = any_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_operation) begin
          i_nxt     = in_particle_index;
          n_nxt     = n_clamp;
          j_nxt     = i_plus;
          any_nxt   = (i_plus < n_clamp);
          state_nxt = ST_RD_I;
        end
      end
      ST_RD_I:  state_nxt = ST_LAT_I;
      ST_LAT_I: begin
        kk_nxt    = '0;
        state_nxt = any_r ? ST_SCAN1 : ST_PREFIX;
      end
      ST_SCAN1: begin
        j_nxt = j_r + CNT_W'(1);
        if (j_r + CNT_W'(1) >= n_r) begin
          state_nxt = ST_DRAIN1;
        end
      end
      ST_DRAIN1: begin
        if (stat.pipe_empty) begin
          state_nxt = ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        kk_nxt = kk_r + IMG_W'(1);
        if (kk_r == IMG_LAST) begin
          j_nxt     = CNT_W'(i_r) + CNT_W'(1);
          state_nxt = any_r ? ST_SCAN2 : ST_DRAIN2;
        end
      end
      ST_SCAN2: begin
        j_nxt = j_r + CNT_W'(1);
        if (j_r + CNT_W'(1) >= n_r) begin
          state_nxt = ST_DRAIN2;
        end
      end
      ST_DRAIN2: begin
        if (stat.pipe_empty) begin
          e_nxt     = '0;
          state_nxt = (hit_count == '0) ? ST_NONE : ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (stat.out_free) begin
          e_nxt     = e_r + HC_W'(1);
          state_nxt = is_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_NONE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    addr      = j_r[IDX_W-1:0];
    kk        = kk_r;
    emit_addr = e_r[HB_AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_wr = accept && !in_operation;
        cmd.start   = accept && in_operation;
      end
      ST_RD_I: begin
        cmd.rd_i = 1'b1;
        addr     = i_r;
      end
      ST_LAT_I:   cmd.cap_ri      = 1'b1;
      ST_SCAN1:   cmd.p1_issue    = 1'b1;
      ST_PREFIX:  cmd.prefix_step = 1'b1;
      ST_SCAN2:   cmd.p2_issue    = 1'b1;
      ST_EMIT_RD: cmd.emit_rd     = 1'b1;
      ST_EMIT_WR: begin
        cmd.out_hit = stat.out_free;
        cmd.first   = (e_r == '0);
        cmd.last    = is_last;
      end
      ST_NONE: cmd.out_none = stat.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      j_r     <= '0;
      n_r     <= '0;
      i_r     <= '0;
      kk_r    <= '0;
      e_r     <= '0;
      any_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
      i_r     <= i_nxt;
      kk_r    <= kk_nxt;
      e_r     <= e_nxt;
      any_r   <= any_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pnl_datapath.sv
// Position store, pair pipeline, image bucketing and result register.
`default_nettype none
module pnl_datapath import pnl_pkg::*; #(
  parameter int RESULT_CAP = 64,
  localparam int HB_AW = (RESULT_CAP > 1) ? $clog2(RESULT_CAP) : 1,
  localparam int HC_W  = $clog2(RESULT_CAP + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [IDX_W-1:0]      in_particle_index,
  input  wire logic [COORD_W-1:0]    in_pos_x,
  input  wire logic [COORD_W-1:0]    in_pos_y,
  input  wire logic [COORD_W-1:0]    in_pos_z,
  input  wire pnl_cmd_t              cmd,
  input  wire logic [IDX_W-1:0]      addr,
  input  wire logic [IMG_W-1:0]      kk,
  input  wire logic [HB_AW-1:0]      emit_addr,
  output pnl_stat_t                  stat,
  output logic [HC_W-1:0]            hit_count,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [IDX_W-1:0]           out_query_index,
  output logic [IDX_W-1:0]           out_neighbor_index,
  output logic [IMG_W-1:0]           out_image_code,
  output logic                       out_group_start,
  output logic                       out_no_neighbors,
  output logic                       out_overflow,
  output logic                       out_last
);

  localparam int HB_W = IDX_W + IMG_W;

  // Configuration registers.
  logic [BOX_W-1:0] box_r [NUM_AXES];
  logic [CUT_W-1:0] cut_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0] <= BOX_W'(40960);
      box_r[1] <= BOX_W'(40960);
      box_r[2] <= BOX_W'(40960);
      cut_r    <= CUT_W'(67108864);
      count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_X:  box_r[0] <= cfg_data[BOX_W-1:0];
        CFG_BOX_Y:  box_r[1] <= cfg_data[BOX_W-1:0];
        CFG_BOX_Z:  box_r[2] <= cfg_data[BOX_W-1:0];
        CFG_CUTOFF: cut_r    <= cfg_data[CUT_W-1:0];
        CFG_COUNT:  count_r  <= cfg_data[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Position store: one word per particle, z in the low bits.
  logic [NUM_AXES*COORD_W-1:0] pos_mem [MAX_PARTICLES];
  logic [NUM_AXES*COORD_W-1:0] pos_rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      pos_mem[in_particle_index] <= {in_pos_x, in_pos_y, in_pos_z};
    end
    if (cmd.rd_i || cmd.p1_issue) begin
      pos_rdata_r <= pos_mem[addr];
    end
  end

  logic signed [COORD_W-1:0] ri_r [NUM_AXES];
  logic [IDX_W-1:0]          qidx_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qidx_r <= in_particle_index;
    end
    if (cmd.cap_ri) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ri_r[a] <= pos_rdata_r[(NUM_AXES-1-a)*COORD_W +: COORD_W];
      end
    end
  end

  // Pair pipeline.
  logic                      v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0]          j0_r, j1_r, j2_r, j3_r, j4_r;
  logic signed [COORD_W:0]   d1_r  [NUM_AXES];
  logic signed [COORD_W+1:0] d2_r  [NUM_AXES];
  logic [1:0]                sc2_r [NUM_AXES];
  logic [COORD_W-1:0]        a3_r  [NUM_AXES];
  logic [2*COORD_W-1:0]      sq4_r [NUM_AXES];
  logic                      far3_r, far4_r;
  logic [IMG_W-1:0]          img3_r, img4_r;

  logic signed [COORD_W:0]   d1_c  [NUM_AXES];
  logic signed [COORD_W+1:0] d2_c  [NUM_AXES];
  logic [1:0]                sc2_c [NUM_AXES];
  logic [COORD_W-1:0]        a3_c  [NUM_AXES];
  logic [NUM_AXES-1:0]       far_c;
  logic [2*COORD_W+1:0]      sum_c;
  logic                      hit_c;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic signed [COORD_W-1:0] rj;
      logic signed [COORD_W+1:0] td, bx, ext, mag;
      rj      = pos_rdata_r[(NUM_AXES-1-a)*COORD_W +: COORD_W];
      d1_c[a] = (COORD_W+1)'(ri_r[a]) - (COORD_W+1)'(rj);
      td      = {d1_r[a], 1'b0};
      bx      = $signed({3'b000, box_r[a]});
      ext     = (COORD_W+2)'(d1_r[a]);
      if (td < -bx) begin
        sc2_c[a] = SHIFT_POS;
        d2_c[a]  = ext + bx;
      end else if (td > bx) begin
        sc2_c[a] = SHIFT_NEG;
        d2_c[a]  = ext - bx;
      end else begin
        sc2_c[a] = SHIFT_ZERO;
        d2_c[a]  = ext;
      end
      far_c[a] = (d2_r[a] >= (COORD_W+2)'(26'sd16777216)) ||
                 (d2_r[a] <= -(COORD_W+2)'(26'sd16777216));
      mag      = d2_r[a][COORD_W+1] ? -d2_r[a] : d2_r[a];
      a3_c[a]  = mag[COORD_W-1:0];
    end
    sum_c = (2*COORD_W+2)'(sq4_r[0]) + (2*COORD_W+2)'(sq4_r[1]) + (2*COORD_W+2)'(sq4_r[2]);
    hit_c = !far4_r && (sum_c < (2*COORD_W+2)'(cut_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= cmd.p1_issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    j0_r   <= addr;
    j1_r   <= j0_r;
    j2_r   <= j1_r;
    j3_r   <= j2_r;
    j4_r   <= j3_r;
    far3_r <= |far_c;
    far4_r <= far3_r;
    img3_r <= img_code(sc2_r[0], sc2_r[1], sc2_r[2]);
    img4_r <= img3_r;
    for (int a = 0; a < NUM_AXES; a++) begin
      d1_r[a]  <= d1_c[a];
      d2_r[a]  <= d2_c[a];
      sc2_r[a] <= sc2_c[a];
      a3_r[a]  <= a3_c[a];
      sq4_r[a] <= a3_r[a] * a3_r[a];
    end
  end

  // Image tag of each partner, written by the first scan and read by the second.
  logic [IMG_W-1:0] img_mem [MAX_PARTICLES];
  logic [IMG_W-1:0] img_rdata_r;
  logic             q_r;
  logic [IDX_W-1:0] qj_r;

  always_ff @(posedge clk) begin
    if (v4_r) begin
      img_mem[j4_r] <= hit_c ? img4_r : IMG_NONE;
    end
    if (cmd.p2_issue) begin
      img_rdata_r <= img_mem[addr];
    end
    qj_r <= addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= 1'b0;
    end else begin
      q_r <= cmd.p2_issue;
    end
  end

  // Per-image counts, turned into running bucket offsets by the prefix pass.
  logic [CNT_W-1:0] slot_r [NUM_IMAGES];
  logic [CNT_W-1:0] acc_r;
  logic             q_hit;
  logic [CNT_W-1:0] q_pos;

  assign q_hit = q_r && (img_rdata_r != IMG_NONE);
  assign q_pos = slot_r[img_rdata_r];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int k = 0; k < NUM_IMAGES; k++) begin
        slot_r[k] <= '0;
      end
      acc_r <= '0;
    end else begin
      if (v4_r && hit_c) begin
        slot_r[img4_r] <= slot_r[img4_r] + CNT_W'(1);
      end
      if (cmd.prefix_step) begin
        slot_r[kk] <= acc_r;
        acc_r      <= acc_r + slot_r[kk];
      end
      if (q_hit) begin
        slot_r[img_rdata_r] <= q_pos + CNT_W'(1);
      end
    end
  end

  // Result buffer in report order.
  logic [HB_W-1:0] hb_mem [RESULT_CAP];
  logic [HB_W-1:0] hb_rdata_r;

  always_ff @(posedge clk) begin
    if (q_hit && (q_pos < CNT_W'(RESULT_CAP))) begin
      hb_mem[q_pos[HB_AW-1:0]] <= {qj_r, img_rdata_r};
    end
    if (cmd.emit_rd) begin
      hb_rdata_r <= hb_mem[emit_addr];
    end
  end

  logic over;
  assign over      = (acc_r > CNT_W'(RESULT_CAP));
  assign hit_count = over ? HC_W'(RESULT_CAP) : acc_r[HC_W-1:0];

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [IMG_W-1:0] prev_img_r;

  assign out_valid_nxt = (cmd.out_hit || cmd.out_none) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_hit) begin
      out_query_index    <= qidx_r;
      out_neighbor_index <= hb_rdata_r[HB_W-1:IMG_W];
      out_image_code     <= hb_rdata_r[IMG_W-1:0];
      out_group_start    <= cmd.first || (hb_rdata_r[IMG_W-1:0] != prev_img_r);
      out_no_neighbors   <= 1'b0;
      out_overflow       <= cmd.last && over;
      out_last           <= cmd.last;
      prev_img_r         <= hb_rdata_r[IMG_W-1:0];
    end else if (cmd.out_none) begin
      out_query_index    <= qidx_r;
      out_neighbor_index <= '0;
      out_image_code     <= '0;
      out_group_start    <= 1'b0;
      out_no_neighbors   <= 1'b1;
      out_overflow       <= 1'b0;
      out_last           <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.pipe_empty = !(v0_r || v1_r || v2_r || v3_r || v4_r || q_r);
  assign stat.count      = count_r;

endmodule
`default_nettype wire
